// ----- hdl/alsd_pkg.sv -----
// ----------------------------------------------------------------------------
// alsd_pkg
// Shared types, codes and widths of the array list search and delete block.
// ----------------------------------------------------------------------------
package alsd_pkg;

    // Default list capacity
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int REQ_W       = 2;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic append_ok;
        logic append_full;
        logic scan_step;
        logic scan_hit;
        logic scan_miss;
        logic shift_step;
        logic shift_end;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             at_end;
        logic             match;
        logic             out_free;
    } stat_t;

endpackage

// ----- hdl/alsd_ram.sv -----
// ----------------------------------------------------------------------------
// alsd_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module alsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/alsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// alsd_ctrl
// Request sequencer: dispatch, scan, shift-down and result hand-off.
// ----------------------------------------------------------------------------
module alsd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  alsd_pkg::stat_t stat,
    output alsd_pkg::cmd_t  cmd
);

    alsd_pkg::state_t state_reg;
    alsd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alsd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alsd_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = alsd_pkg::S_DISPATCH;
                end
            end
            alsd_pkg::S_DISPATCH:
            begin
                case (stat.req)
                    alsd_pkg::REQ_SEARCH, alsd_pkg::REQ_DELETE:
                    begin
                        state_next = alsd_pkg::S_SCAN;
                    end
                    default:
                    begin
                        state_next = alsd_pkg::S_RESULT;
                    end
                endcase
            end
            alsd_pkg::S_SCAN:
            begin
                if (stat.at_end)
                begin
                    state_next = alsd_pkg::S_RESULT;
                end
                else if (stat.match)
                begin
                    state_next = (stat.req == alsd_pkg::REQ_DELETE) ?
                                 alsd_pkg::S_SHIFT : alsd_pkg::S_RESULT;
                end
            end
            alsd_pkg::S_SHIFT:
            begin
                if (stat.at_end)
                begin
                    state_next = alsd_pkg::S_RESULT;
                end
            end
            alsd_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = alsd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = alsd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            alsd_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            alsd_pkg::S_DISPATCH:
            begin
                if (stat.req == alsd_pkg::REQ_APPEND)
                begin
                    cmd.append_ok   = !stat.full;
                    cmd.append_full = stat.full;
                end
            end
            alsd_pkg::S_SCAN:
            begin
                if (stat.at_end)
                begin
                    cmd.scan_miss = 1'b1;
                end
                else if (stat.match)
                begin
                    cmd.scan_hit = 1'b1;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            alsd_pkg::S_SHIFT:
            begin
                cmd.shift_end  = stat.at_end;
                cmd.shift_step = !stat.at_end;
            end
            alsd_pkg::S_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/alsd_dp.sv -----
// ----------------------------------------------------------------------------
// alsd_dp
// Datapath: entry RAM, count, scan index, result fields and output register.
// ----------------------------------------------------------------------------
module alsd_dp #(
    parameter int CAPACITY = alsd_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [alsd_pkg::REQ_W-1:0]          in_req,
    input  logic [alsd_pkg::VALUE_W-1:0]        in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [alsd_pkg::OUT_TDATA_W-1:0]    out_data,
    input  alsd_pkg::cmd_t                      cmd,
    output alsd_pkg::stat_t                     stat
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PAD_W = alsd_pkg::OUT_TDATA_W - 1 - alsd_pkg::POS_W
                           - alsd_pkg::CNT_W - alsd_pkg::STAT_W;

    logic [alsd_pkg::REQ_W-1:0]    req_reg;
    logic [alsd_pkg::VALUE_W-1:0]  key_reg;
    logic [CW-1:0]                 idx_reg;
    logic [CW-1:0]                 idx_next;
    logic [CW-1:0]                 idx_m1;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          found_reg;
    logic [IW-1:0]                 pos_reg;
    logic [alsd_pkg::STAT_W-1:0]   status_reg;
    logic                          out_valid_reg;
    logic [alsd_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [alsd_pkg::VALUE_W-1:0]  ram_wdata;
    logic [alsd_pkg::VALUE_W-1:0]  ram_rdata;

    logic [IW+alsd_pkg::POS_W-1:0] pos_wide;
    logic [CW+alsd_pkg::CNT_W-1:0] count_wide;

    // Read address follows the next index so read data lines up with idx_reg
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_req)
        begin
            idx_next = '0;
        end
        else if (cmd.scan_step || cmd.scan_hit || cmd.shift_step)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    assign idx_m1 = idx_reg - CW'(1);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.append_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.shift_end)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign ram_we    = cmd.append_ok || cmd.shift_step;
    assign ram_waddr = cmd.append_ok ? count_reg[IW-1:0] : idx_m1[IW-1:0];
    assign ram_wdata = cmd.append_ok ? key_reg : ram_rdata;

    alsd_ram #(
        .WIDTH (alsd_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_next[IW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pos_wide   = {{alsd_pkg::POS_W{1'b0}}, pos_reg};
    assign count_wide = {{alsd_pkg::CNT_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg    <= in_req;
            key_reg    <= in_value;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
            status_reg <= alsd_pkg::ST_DONE;
        end
        if (cmd.append_ok)
        begin
            pos_reg <= count_reg[IW-1:0];
        end
        if (cmd.append_full)
        begin
            status_reg <= alsd_pkg::ST_FULL;
        end
        if (cmd.scan_miss)
        begin
            status_reg <= alsd_pkg::ST_NOTFOUND;
        end
        if (cmd.scan_hit)
        begin
            found_reg <= 1'b1;
            pos_reg   <= idx_reg[IW-1:0];
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, status_reg,
                             count_wide[alsd_pkg::CNT_W-1:0],
                             pos_wide[alsd_pkg::POS_W-1:0], found_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.req      = req_reg;
    assign stat.full     = (count_reg >= CW'(CAPACITY));
    assign stat.at_end   = (idx_reg >= count_reg);
    assign stat.match    = (ram_rdata == key_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

// ----- hdl/array_list_search_delete.sv -----
// ----------------------------------------------------------------------------
// array_list_search_delete
// Fixed-capacity list of signed words with append, search and delete-shift.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result beat. Append and the
// unused request kind go from dispatch straight to the result state; search
// and delete pass through the scan state, and delete also the shift state,
// since the entry RAM is visited one entry per cycle through its single
// registered read port, first to find the key and then, for delete, to move
// each later entry down one place. The next request is accepted in the cycle
// after the previous result has been placed in the output register, even if
// it has not been taken yet; the result state waits while the output register
// still holds a beat that has not been taken.
module array_list_search_delete #(
    parameter int CAPACITY = alsd_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [alsd_pkg::IN_TDATA_W-1:0]  s_tdata,  // [31:0] value
    input  logic [alsd_pkg::REQ_W-1:0]       s_tuser,  // [1:0] req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] found, [4:1] position, [9:5] entry_count, [11:10] status, [15:12] zero
    output logic [alsd_pkg::OUT_TDATA_W-1:0] m_tdata
);

    alsd_pkg::cmd_t  cmd;
    alsd_pkg::stat_t stat;

    alsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    alsd_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (s_tuser),
        .in_value  (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    logic                        res_found;
    logic [alsd_pkg::POS_W-1:0]  res_pos;
    logic [alsd_pkg::STAT_W-1:0] res_status;

    assign res_found  = m_tdata[0];
    assign res_pos    = m_tdata[4:1];
    assign res_status = m_tdata[11:10];

    // One request in flight: no back-to-back acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in progress");

    // A match always completes with done status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_found) |-> (res_status == alsd_pkg::ST_DONE))
        else $error("found result with non-done status");

    // Refused or missed requests report position zero and no match
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status == alsd_pkg::ST_NOTFOUND ||
                      res_status == alsd_pkg::ST_FULL))
        |-> (!res_found && res_pos == '0))
        else $error("failed request carries a position or match flag");

endmodule

// ----- sim/array_list_search_delete_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_list_search_delete_test
// Self-checking bench for the array list search and delete block. A queue of
// append, search and delete requests is streamed in under random backpressure.
// Each accepted request is run through a behavioral copy of the list, and
// every result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module array_list_search_delete_test;

    import alsd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 40;
    localparam int ITEMS_PER_MIX = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [REQ_W-1:0]          kind;
        logic signed [VALUE_W-1:0] value;
    } list_req_t;

    // Field order matches m_tdata[11:0], status in the top bits
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  cnt;
        logic [POS_W-1:0]  pos;
        logic              found;
    } list_resp_t;

    typedef struct packed {
        logic [CNT_W-1:0]                       cnt;
        logic [CAPACITY_DEF-1:0][VALUE_W-1:0]   words;
    } list_image_t;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } req_mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    list_req_t   pending_reqs[$];
    list_resp_t  expected_results[$];
    list_image_t stim_list;
    list_image_t model_list;

    list_req_t   next_req;
    list_req_t   taken_req;
    list_resp_t  predicted;
    list_resp_t  observed;
    list_resp_t  oldest;

    logic s_took = 1'b0;
    int   src_idle_pct = 17;
    int   snk_idle_pct = 61;
    int   stall_cycles = 0;
    int   n_queued = 0;
    int   n_accepted = 0;
    int   mismatches = 0;

    array_list_search_delete #(
        .CAPACITY (CAPACITY_DEF)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Apply one request to a list image and give the result it yields
    task automatic apply_request(inout list_image_t img, input list_req_t rq,
                                 output list_resp_t rsp);
        int i;
        int hit;
        rsp = '0;
        rsp.status = ST_DONE;
        case (rq.kind)
            REQ_APPEND:
            begin
                if (img.cnt >= CAPACITY_DEF)
                    rsp.status = ST_FULL;
                else
                begin
                    img.words[img.cnt] = rq.value;
                    rsp.pos = img.cnt[POS_W-1:0];
                    img.cnt = img.cnt + 1'b1;
                end
            end
            REQ_SEARCH, REQ_DELETE:
            begin
                hit = img.cnt;
                // walk down so the lowest matching position wins
                for (i = CAPACITY_DEF - 1; i >= 0; i--)
                    if (i < img.cnt && img.words[i] == rq.value)
                        hit = i;
                if (hit == img.cnt)
                    rsp.status = ST_NOTFOUND;
                else
                begin
                    rsp.found = 1'b1;
                    rsp.pos = hit[POS_W-1:0];
                    if (rq.kind == REQ_DELETE)
                    begin
                        for (i = 0; i < CAPACITY_DEF - 1; i++)
                            if (i >= hit && i + 1 < img.cnt)
                                img.words[i] = img.words[i + 1];
                        img.cnt = img.cnt - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        rsp.cnt = img.cnt;
    endtask

    // Queue a request and keep the stimulus-side list in step with it
    task automatic queue_request(input logic [REQ_W-1:0] kind,
                                 input logic [VALUE_W-1:0] value);
        list_req_t  rq;
        list_resp_t unused_rsp;
        rq.kind = kind;
        rq.value = value;
        apply_request(stim_list, rq, unused_rsp);
        pending_reqs.push_back(rq);
        n_queued++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(7, 0);
        if (r < 2)
            v = $urandom_range(7, 0);
        else if (r == 2)
        begin
            case ($urandom_range(3, 0))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        else
            v = $urandom;
        return v;
    endfunction

    task automatic queue_random(input int n_items);
        int       done_items;
        int       roll;
        int       left_in_mix;
        req_mix_t mix;
        logic [REQ_W-1:0]   kind;
        logic [VALUE_W-1:0] key;
        done_items = 0;
        left_in_mix = 0;
        mix = MIX_EVEN;
        while (done_items < n_items)
        begin
            if (left_in_mix == 0)
            begin
                mix = req_mix_t'($urandom_range(2, 0));
                left_in_mix = $urandom_range(32, 16);
            end
            left_in_mix--;
            roll = $urandom_range(99, 0);
            case (mix)
                MIX_GROW:   kind = roll < 65 ? REQ_APPEND : roll < 80 ? REQ_SEARCH :
                                   roll < 96 ? REQ_DELETE : REQ_UNUSED;
                MIX_SHRINK: kind = roll < 20 ? REQ_APPEND : roll < 40 ? REQ_SEARCH :
                                   roll < 96 ? REQ_DELETE : REQ_UNUSED;
                default:    kind = roll < 38 ? REQ_APPEND : roll < 63 ? REQ_SEARCH :
                                   roll < 96 ? REQ_DELETE : REQ_UNUSED;
            endcase
            // mostly aim searches and deletes at keys that are in the list
            if (kind != REQ_APPEND && stim_list.cnt > 0 && $urandom_range(99, 0) < 75)
                key = stim_list.words[$urandom_range(stim_list.cnt - 1, 0)];
            else
                key = pick_value();
            queue_request(kind, key);
            if (kind != REQ_UNUSED)
                done_items++;
        end
    endtask

    // Hold the sender until every queued request has its result back
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Request driver: advance on a taken beat or when nothing is offered
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_took)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= src_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_req.value;
                s_tuser <= next_req.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end

    // Monitor: check result beats first, then predict for the request beat
    always @(posedge clk)
    begin
        s_took <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                observed = list_resp_t'(m_tdata[11:0]);
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result beat %h with nothing expected",
                                 $realtime, m_tdata);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("found", oldest.found, observed.found);
                    check_field("position", oldest.pos, observed.pos);
                    check_field("entry_count", oldest.cnt, observed.cnt);
                    check_field("status", oldest.status, observed.status);
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken_req = {s_tuser, s_tdata};
                apply_request(model_list, taken_req, predicted);
                expected_results.push_back(predicted);
                n_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int i;
        stim_list = '0;
        model_list = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list: misses and the unused kind
        queue_request(REQ_SEARCH, 32'd5);
        queue_request(REQ_DELETE, 32'd5);
        queue_request(REQ_UNUSED, 32'd0);
        // fill to capacity with extremes and a duplicate
        queue_request(REQ_APPEND, 32'h8000_0000);
        queue_request(REQ_APPEND, 32'h7fff_ffff);
        queue_request(REQ_APPEND, 32'h0000_0000);
        queue_request(REQ_APPEND, 32'hffff_ffff);
        queue_request(REQ_APPEND, 32'd5);
        queue_request(REQ_APPEND, 32'd5);
        for (i = 0; i < 10; i++)
            queue_request(REQ_APPEND, 32'd100 + i);
        queue_request(REQ_APPEND, 32'd1);
        queue_request(REQ_SEARCH, 32'd5);
        queue_request(REQ_SEARCH, 32'd12345);
        // drop the last entry, then the first one
        queue_request(REQ_DELETE, 32'd109);
        queue_request(REQ_DELETE, 32'h8000_0000);
        queue_request(REQ_UNUSED, 32'hffff_ffff);
        queue_request(REQ_SEARCH, 32'h7fff_ffff);
        queue_random(ITEMS_PER_MIX);
        wait_drained();

        src_idle_pct = 61;
        snk_idle_pct = 17;
        queue_random(ITEMS_PER_MIX);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(ITEMS_PER_MIX);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
